/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// MLCD_ASSERT checks on every rising clock edge outside reset.
// MLCD_ASSERT_ANY checks on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("mlcd assertion failed");
`define MLCD_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mlcd assertion failed");
`else
`define MLCD_ASSERT(lbl, clk, rstn, prop)
`define MLCD_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

/* hw/rtl/mlcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mlcd_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int PAT_DIGITS      = 4;
  localparam int SEG_W           = 8;
  localparam int SEG_PAIRS       = SEG_W / 2;
  localparam int COM_W           = 4;
  localparam int PHASE_W         = 3;
  localparam int MODE_W          = 3;
  localparam int VALUE_W         = 14;
  localparam int DIGIT_W         = 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

  localparam logic [7:0] SEG_POINT = 8'h10;
  localparam logic [7:0] SEG_DASH  = 8'h04;
  localparam logic [7:0] SEG_E     = 8'h8f;
  localparam logic [7:0] SEG_R     = 8'h0e;
  localparam logic [7:0] SEG_N     = 8'hea;
  localparam logic [7:0] SEG_D     = 8'h67;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SET  = 1'b1
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NUMBER = 3'd0,
    MODE_ERROR  = 3'd1,
    MODE_END    = 3'd2,
    MODE_DASHES = 3'd3,
    MODE_BLANK  = 3'd4
  } content_mode_e;

  typedef struct packed {
    logic               action;
    logic [MODE_W-1:0]  content_mode;
    logic [VALUE_W-1:0] display_value;
  } item_t;

  typedef struct packed {
    logic [COM_W-1:0] com_lines;
    logic [SEG_W-1:0] seg_lines;
    logic             frame_polarity;
  } result_t;

  typedef logic [PAT_DIGITS-1:0][7:0] pattern_t;

  function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'heb;
      4'd1:    g = 8'h60;
      4'd2:    g = 8'hc7;
      4'd3:    g = 8'he5;
      4'd4:    g = 8'h6c;
      4'd5:    g = 8'had;
      4'd6:    g = 8'haf;
      4'd7:    g = 8'he0;
      4'd8:    g = 8'hef;
      4'd9:    g = 8'hed;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mlcd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mlcd_in_if import mlcd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [MODE_W-1:0]  content_mode;
  logic [VALUE_W-1:0] display_value;

  modport source (output valid, output action, output content_mode,
                  output display_value, input ready);
  modport sink   (input valid, input action, input content_mode,
                  input display_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mlcd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mlcd_out_if import mlcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [COM_W-1:0] com_lines;
  logic [SEG_W-1:0] seg_lines;
  logic             frame_polarity;

  modport source (output valid, output com_lines, output seg_lines,
                  output frame_polarity, input ready);
  modport sink   (input valid, input com_lines, input seg_lines,
                  input frame_polarity, output ready);
endinterface
`default_nettype wire

/* hw/rtl/multiplexed_lcd_digit_driver.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Channel  Dir  Payload                                      Accepted when
// in_i     in   action, content_mode, display_value          valid && ready
// out_o    out  com_lines, seg_lines, frame_polarity          valid && ready
//
// One word in, one word out. A word waits in the input register and moves on to the
// result register once that is empty or being read: one word per cycle sustained
// unless out_o stalls. The scan state updates as the word leaves the input register.
// Reset clears the scan state, the segment buffers and both valid flags.
// A stalled result holds; the input register keeps accepting until it is full too.
module multiplexed_lcd_digit_driver import mlcd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mlcd_in_if.sink      in_i,
  mlcd_out_if.source   out_o
);

  logic     s1_valid_q;
  item_t    s1_item_q;
  logic     out_valid_q;
  result_t  out_res_q;
  result_t  res_d;
  pattern_t pat;
  logic     take;
  logic     advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.action        <= in_i.action;
      s1_item_q.content_mode  <= in_i.content_mode;
      s1_item_q.display_value <= in_i.display_value;
    end
    if (advance) out_res_q <= res_d;
  end

  mlcd_encoder u_encoder (
    .mode_i  (s1_item_q.content_mode),
    .value_i (s1_item_q.display_value),
    .pat_o   (pat),
    .take_o  (take)
  );

  mlcd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .pat_i     (pat),
    .take_i    (take),
    .result_o  (res_d)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.com_lines      = out_res_q.com_lines;
  assign out_o.seg_lines      = out_res_q.seg_lines;
  assign out_o.frame_polarity = out_res_q.frame_polarity;

  `MLCD_ASSERT_ANY(a_reset_empty, clk_i, !rst_ni |=> !out_o.valid && !s1_valid_q)
  `MLCD_ASSERT(a_advance_lands, clk_i, rst_ni, advance |=> out_o.valid)
  `MLCD_ASSERT(a_word_kept, clk_i, rst_ni, s1_valid_q && !advance |=> s1_valid_q)

endmodule
`default_nettype wire

/* hw/rtl/mlcd_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlcd_encoder import mlcd_pkg::*; (
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [VALUE_W-1:0] value_i,
  output pattern_t           pat_o,
  output logic               take_o
);

  logic [VALUE_W-1:0] value_sat;
  logic [DIGIT_W-1:0] thou, hund, tens, unit;
  logic [9:0]         rem_thou;
  logic [6:0]         rem_hund;

  // Split into decimal digits with parallel threshold compares per digit.
  always_comb begin
    value_sat = (value_i > VALUE_MAX) ? VALUE_MAX : value_i;

    thou = '0;
    for (int k = 1; k < 10; k++) begin
      if (value_sat >= VALUE_W'(k * 1000)) thou = DIGIT_W'(k);
    end
    rem_thou = 10'(value_sat - VALUE_W'(thou) * VALUE_W'(1000));

    hund = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_thou >= 10'(k * 100)) hund = DIGIT_W'(k);
    end
    rem_hund = 7'(rem_thou - 10'(hund) * 10'(100));

    tens = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_hund >= 7'(k * 10)) tens = DIGIT_W'(k);
    end
    unit = DIGIT_W'(rem_hund - 7'(tens) * 7'(10));
  end

  always_comb begin
    take_o = 1'b1;
    pat_o  = '0;
    unique case (mode_i)
      MODE_NUMBER: begin
        pat_o[0] = (thou != '0) ? digit_glyph(thou) : 8'h00;
        pat_o[1] = digit_glyph(hund) | SEG_POINT;
        pat_o[2] = digit_glyph(tens);
        pat_o[3] = digit_glyph(unit);
      end
      MODE_ERROR: begin
        pat_o[0] = SEG_DASH;
        pat_o[1] = SEG_E;
        pat_o[2] = SEG_R;
        pat_o[3] = SEG_R;
      end
      MODE_END: begin
        pat_o[1] = SEG_E;
        pat_o[2] = SEG_N;
        pat_o[3] = SEG_D;
      end
      MODE_DASHES: begin
        pat_o = {PAT_DIGITS{SEG_DASH}};
      end
      MODE_BLANK: begin
        pat_o = '0;
      end
      default: begin
        // unknown mode: leave the buffer alone
        take_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/mlcd_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mlcd_scan import mlcd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  item_t    item_i,
  input  pattern_t pat_i,
  input  logic     take_i,
  output result_t  result_o
);

  logic [7:0]         segbuf_q   [DIGIT_COUNT];
  logic [7:0]         scanmem_q  [DIGIT_COUNT];
  logic [7:0]         segbuf_d   [DIGIT_COUNT];
  logic [7:0]         scan_src   [DIGIT_COUNT];
  logic [PHASE_W-1:0] phase_q;
  logic               frame_q;
  logic [SEG_W-1:0]   seg_d;
  logic               is_tick;

  assign is_tick = (item_i.action == ACT_TICK);

  for (genvar gi = 0; gi < DIGIT_COUNT; gi++) begin : g_digit
    if (gi < PAT_DIGITS) begin : g_pat
      assign segbuf_d[gi] = pat_i[gi];
    end else begin : g_zero
      assign segbuf_d[gi] = 8'h00;
    end
    // phase zero scans straight from the freshly copied buffer
    assign scan_src[gi] = (phase_q == '0) ? segbuf_q[gi] : scanmem_q[gi];
  end

  for (genvar gi = 0; gi < SEG_PAIRS; gi++) begin : g_seg
    if (gi < DIGIT_COUNT) begin : g_drive
      assign seg_d[2*gi]   = scan_src[gi][0];
      assign seg_d[2*gi+1] = scan_src[gi][4];
    end else begin : g_off
      assign seg_d[2*gi]   = 1'b0;
      assign seg_d[2*gi+1] = 1'b0;
    end
  end

  always_comb begin
    if (is_tick) begin
      result_o.com_lines      = COM_W'(1) << phase_q[PHASE_W-1:1];
      result_o.seg_lines      = seg_d;
      result_o.frame_polarity = ~frame_q;
    end else begin
      result_o.com_lines      = '0;
      result_o.seg_lines      = '0;
      result_o.frame_polarity = frame_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        segbuf_q[i]  <= 8'h00;
        scanmem_q[i] <= 8'h00;
      end
      phase_q <= '0;
      frame_q <= 1'b0;
    end else if (advance_i) begin
      if (is_tick) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          // shift after odd phases
          scanmem_q[i] <= phase_q[0] ? (scan_src[i] >> 1) : scan_src[i];
        end
        phase_q <= phase_q + PHASE_W'(1);
        frame_q <= ~frame_q;
      end else if (take_i) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          segbuf_q[i] <= segbuf_d[i];
        end
      end
    end
  end

  `MLCD_ASSERT(a_phase_step, clk_i, rst_ni,
    advance_i && is_tick |=> phase_q == PHASE_W'($past(phase_q) + PHASE_W'(1)))
  `MLCD_ASSERT(a_frame_flip, clk_i, rst_ni,
    advance_i && is_tick |=> frame_q != $past(frame_q))
  `MLCD_ASSERT(a_scan_hold, clk_i, rst_ni,
    !advance_i || !is_tick |=> $stable(phase_q) && $stable(frame_q))
  `MLCD_ASSERT(a_com_onehot, clk_i, rst_ni,
    is_tick |-> $onehot(result_o.com_lines))

endmodule
`default_nettype wire

/* sim/tb_multiplexed_lcd_digit_driver.sv */
`timescale 1ns / 1ps
module tb_multiplexed_lcd_digit_driver import mlcd_pkg::*;;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 8;
  localparam int RANDOM_WORDS    = 1590;

  // Mode codes the block must ignore
  localparam logic [MODE_W-1:0] MODE_RESERVED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESERVED_LAST  = 3'd7;

  // Seven-segment glyphs for 0..9, digit 0 in the low byte
  localparam logic [9:0][7:0] GLYPH_ROM = {8'hed, 8'hef, 8'he0, 8'haf, 8'had,
                                           8'h6c, 8'he5, 8'hc7, 8'h60, 8'heb};

  logic clk_i = 1'b0;
  logic rst_ni;

  mlcd_in_if  in_if ();
  mlcd_out_if out_if ();

  multiplexed_lcd_digit_driver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Display state mirrored by the predictor
  pattern_t          seg_buffer_m = '0;
  pattern_t          scan_mem_m   = '0;
  logic [PHASE_W-1:0] phase_m     = '0;
  logic              frame_m      = 1'b0;

  result_t lcd_drive_q[$];
  int      words_sent       = 0;
  int      drive_mismatches = 0;
  int      idle_cycles      = 0;
  int      hold_off_left    = 0;
  logic    src_idle_en      = 1'b0;
  logic    sink_idle_en     = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t predict_drive(input action_e act,
                                            input logic [MODE_W-1:0] mode,
                                            input logic [VALUE_W-1:0] value);
    result_t            r;
    logic [VALUE_W-1:0] v;
    int                 thou, hund, tens, unit;
    r = '0;
    if (act == ACT_SET) begin
      v    = (value > VALUE_MAX) ? VALUE_MAX : value;
      thou = v / 1000;
      hund = (v / 100) % 10;
      tens = (v / 10) % 10;
      unit = v % 10;
      case (mode)
        MODE_NUMBER: begin
          seg_buffer_m[0] = (thou != 0) ? GLYPH_ROM[thou] : 8'h00;
          seg_buffer_m[1] = GLYPH_ROM[hund] | SEG_POINT;
          seg_buffer_m[2] = GLYPH_ROM[tens];
          seg_buffer_m[3] = GLYPH_ROM[unit];
        end
        MODE_ERROR: begin
          seg_buffer_m[0] = SEG_DASH;
          seg_buffer_m[1] = SEG_E;
          seg_buffer_m[2] = SEG_R;
          seg_buffer_m[3] = SEG_R;
        end
        MODE_END: begin
          seg_buffer_m[0] = 8'h00;
          seg_buffer_m[1] = SEG_E;
          seg_buffer_m[2] = SEG_N;
          seg_buffer_m[3] = SEG_D;
        end
        MODE_DASHES: seg_buffer_m = {4{SEG_DASH}};
        MODE_BLANK:  seg_buffer_m = '0;
        default: ;
      endcase
      r.frame_polarity = frame_m;
    end else begin
      // Latch a fresh frame at the start of each scan
      if (phase_m == '0) scan_mem_m = seg_buffer_m;
      r.com_lines = COM_W'(1) << phase_m[2:1];
      frame_m = ~frame_m;
      for (int i = 0; i < SEG_PAIRS; i++) begin
        r.seg_lines[2*i]   = scan_mem_m[i][0];
        r.seg_lines[2*i+1] = scan_mem_m[i][4];
      end
      if (phase_m[0]) begin
        for (int i = 0; i < PAT_DIGITS; i++) scan_mem_m[i] = scan_mem_m[i] >> 1;
      end
      phase_m = phase_m + 1'b1;
      r.frame_polarity = frame_m;
    end
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input action_e act, input logic [MODE_W-1:0] mode,
                           input logic [VALUE_W-1:0] value);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    repeat (gap) @(negedge clk_i);
    in_if.valid         = 1'b1;
    in_if.action        = act;
    in_if.content_mode  = mode;
    in_if.display_value = value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    lcd_drive_q.push_back(predict_drive(act, mode, value));
    words_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(ACT_TICK, MODE_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic wait_drained();
    while (lcd_drive_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver side: random stalls plus an optional long hold-off
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_if.ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if (sink_idle_en) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (lcd_drive_q.size() == 0) begin
        drive_mismatches++;
        if (drive_mismatches <= REPORT_LIMIT)
          $display("%0t: drive word with none expected: com=%h seg=%h pol=%b",
                   $time, out_if.com_lines, out_if.seg_lines, out_if.frame_polarity);
      end else begin
        want = lcd_drive_q.pop_front();
        if (out_if.com_lines !== want.com_lines || out_if.seg_lines !== want.seg_lines ||
            out_if.frame_polarity !== want.frame_polarity) begin
          drive_mismatches++;
          if (drive_mismatches <= REPORT_LIMIT)
            $display("%0t: drive word mismatch: expected com=%h seg=%h pol=%b, got com=%h seg=%h pol=%b",
                     $time, want.com_lines, want.seg_lines, want.frame_polarity,
                     out_if.com_lines, out_if.seg_lines, out_if.frame_polarity);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Scan from reset shows an empty buffer
  task automatic test_reset_state();
    send_word(ACT_TICK, MODE_NUMBER, '0);
    send_word(ACT_TICK, MODE_RESERVED_LAST, '1);
  endtask

  // Oversized numbers clamp to 9999; reserved modes leave the buffer alone
  task automatic test_saturation_and_ignored_modes();
    send_word(ACT_SET, MODE_NUMBER, '1);
    send_word(ACT_SET, MODE_RESERVED_FIRST, VALUE_W'(1234));
    send_word(ACT_SET, MODE_RESERVED_FIRST + 1'b1, '1);
    send_word(ACT_SET, MODE_RESERVED_LAST, '0);
    send_ticks(6);
    send_ticks(8);
  endtask

  task automatic test_every_pattern();
    send_word(ACT_SET, MODE_ERROR, '0);
    send_word(ACT_SET, MODE_END, '1);
    send_word(ACT_SET, MODE_DASHES, '0);
    send_word(ACT_SET, MODE_BLANK, '1);
    send_word(ACT_SET, MODE_NUMBER, '0);
  endtask

  // Hold the output long enough that the input backs up
  task automatic test_backpressure_fill();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    send_word(ACT_SET, MODE_NUMBER, VALUE_W'(8088));
    send_ticks(20);
  endtask

  task automatic test_pause_until_drained();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_word(ACT_SET, MODE_NUMBER, VALUE_W'(1005));
    send_ticks(5);
    wait_drained();
    send_ticks(6);
  endtask

  task automatic test_random_frames(input int n_words);
    int                 first;
    int                 r;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    first = words_sent;
    while (words_sent - first < n_words) begin
      if (words_sent - first < 120) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 80) begin
        // Load a pattern, then scan it for a while
        r = $urandom_range(0, 99);
        if (r < 45)
          mode = MODE_NUMBER;
        else if (r < 94)
          mode = MODE_W'($urandom_range(MODE_ERROR, MODE_BLANK));
        else
          mode = MODE_W'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST));
        r = $urandom_range(0, 99);
        if (r < 10)
          value = VALUE_W'($urandom_range(VALUE_MAX + 1, 2**VALUE_W - 1));
        else if (r < 20)
          value = VALUE_W'((10 ** $urandom_range(0, 4)) - $urandom_range(0, 1));
        else
          value = VALUE_W'($urandom_range(0, VALUE_MAX));
        send_word(ACT_SET, mode, value);
        send_ticks($urandom_range(1, 20));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(action_e'($urandom_range(0, 1)), MODE_W'($urandom), VALUE_W'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.action        = ACT_TICK;
    in_if.content_mode  = MODE_NUMBER;
    in_if.display_value = '0;
    rst_ni              = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_saturation_and_ignored_modes();
    test_every_pattern();
    test_backpressure_fill();
    test_pause_until_drained();
    test_random_frames(RANDOM_WORDS);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (lcd_drive_q.size() != 0) drive_mismatches++;
    if (drive_mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mlcd_pkg.sv
hw/rtl/mlcd_in_if.sv
hw/rtl/mlcd_out_if.sv
hw/rtl/mlcd_encoder.sv
hw/rtl/mlcd_scan.sv
hw/rtl/multiplexed_lcd_digit_driver.sv
sim/tb_multiplexed_lcd_digit_driver.sv
